// ----- src/top_k_selector_macros.svh -----
// Assertion macros for the top-k selector
`ifndef TOP_K_SELECTOR_MACROS_SVH
`define TOP_K_SELECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define TK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tk_pkg.sv -----
// Shared types and constants for the top-k selector
package tk_pkg;

    localparam int SLOTS           = 63;
    localparam int SCORE_W         = 32;
    localparam int IDX_W           = 6;
    localparam int KEEP_W          = 6;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 6;
    localparam int MAX_CLASSES_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE = 1'b1;

    localparam logic [MODE_W-1:0] MODE_VALUES  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INDICES = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTH    = 2'd2;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] top_value;
        logic [IDX_W-1:0]          class_index;
        logic                      rank_last;
    } out_word_t;

    typedef struct packed {
        logic                      valid;
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          index;
    } entry_t;

    typedef struct packed {
        logic ins_en;
        logic shift_up;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- src/tk_cell.sv -----
// One slot of the sorted insertion chain
module tk_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tk_pkg::cell_ctrl_t ctrl,
    input  tk_pkg::entry_t     new_entry,
    input  tk_pkg::entry_t     prev_entry,
    input  logic               prev_take,
    input  tk_pkg::entry_t     next_entry,
    output tk_pkg::entry_t     entry,
    output logic               take
);
    import tk_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    logic [IDX_W-1:0]          index_reg;
    logic [IDX_W-1:0]          index_next;

    // strict compare: an equal score stays behind the earlier one
    assign take = !valid_reg || (new_entry.score > score_reg);

    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        index_next = index_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift_up)
        begin
            valid_next = next_entry.valid;
            score_next = next_entry.score;
            index_next = next_entry.index;
        end
        else if (ctrl.ins_en && take)
        begin
            if (prev_take)
            begin
                valid_next = prev_entry.valid;
                score_next = prev_entry.score;
                index_next = prev_entry.index;
            end
            else
            begin
                valid_next = 1'b1;
                score_next = new_entry.score;
                index_next = new_entry.index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        index_reg <= index_next;
    end

    assign entry = '{valid: valid_reg, score: score_reg, index: index_reg};

endmodule

// ----- src/tk_chain.sv -----
// Row of cells holding the descending list; head is the best entry
module tk_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  tk_pkg::cell_ctrl_t ctrl,
    input  tk_pkg::entry_t     new_entry,
    output tk_pkg::entry_t     head
);
    import tk_pkg::*;

    entry_t entries [SLOTS];
    logic   takes   [SLOTS];

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_t;

        if (i == 0)
        begin : g_first
            assign prev_e = new_entry;
            assign prev_t = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = entries[i-1];
            assign prev_t = takes[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_body
            assign next_e = entries[i+1];
        end

        tk_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_take  (prev_t),
            .next_entry (next_e),
            .entry      (entries[i]),
            .take       (takes[i])
        );
    end

    assign head = entries[0];

endmodule

// ----- src/top_k_selector.sv -----
// Top-k selector: top level with row control, unload and configuration
// A row of scores streams in at one word per cycle into a 63-slot insertion
// chain that keeps the best scores in descending order, ties in row order.
// Input is stalled after the word marked last_in until the row is unloaded:
// the chain head is read out one result word per cycle while out_stall is
// low, min(row length, MAX_CLASSES, 63, keep_count) words. Scores at
// positions beyond MAX_CLASSES are ignored but their last_in mark still
// closes the row.
module top_k_selector #(
    parameter int MAX_CLASSES = tk_pkg::MAX_CLASSES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tk_pkg::in_word_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tk_pkg::out_word_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tk_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tk_pkg::*;

    `include "top_k_selector_macros.svh"

    localparam int CW = $clog2(MAX_CLASSES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CLASSES);
    localparam logic [KEEP_W-1:0] FILL_FULL = KEEP_W'(SLOTS);

    typedef enum logic {ST_RUN, ST_DRAIN} state_t;

    state_t            state_reg,     state_next;
    logic [CW-1:0]     counter_reg,   counter_next;
    logic [KEEP_W-1:0] fill_reg,      fill_next;
    logic [KEEP_W-1:0] remaining_reg, remaining_next;
    logic [KEEP_W-1:0] keep_reg,      keep_next;
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg,  out_data_next;

    logic              in_accept;
    logic              ins_en;
    logic              load_word;
    logic              last_load;
    logic              cnt_full;
    logic [KEEP_W-1:0] fill_after;
    logic [KEEP_W-1:0] emit_n;
    logic [CW+IDX_W-1:0] cnt_wide;
    cell_ctrl_t        ctrl;
    entry_t            new_entry;
    entry_t            head;

    assign in_stall  = (state_reg != ST_RUN);
    assign in_accept = in_valid && !in_stall;
    assign ins_en    = in_accept && (counter_reg < CNT_MAX);
    assign cfg_ready = 1'b1;

    assign cnt_wide  = {{IDX_W{1'b0}}, counter_reg};
    assign new_entry = '{valid: 1'b1, score: in_data.score, index: cnt_wide[IDX_W-1:0]};

    assign fill_after = (ins_en && (fill_reg != FILL_FULL)) ? fill_reg + 1'b1 : fill_reg;
    assign emit_n     = (fill_after > keep_reg) ? keep_reg : fill_after;

    assign load_word = (state_reg == ST_DRAIN) && (!out_valid_reg || !out_stall);
    assign last_load = load_word && (remaining_reg == KEEP_W'(1));
    assign cnt_full  = (counter_reg == CNT_MAX);

    tk_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_entry (new_entry),
        .head      (head)
    );

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        fill_next      = fill_reg;
        remaining_next = remaining_reg;
        keep_next      = keep_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ctrl           = '{ins_en: ins_en, shift_up: 1'b0, clear: 1'b0};

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEEP_COUNT:  keep_next = cfg_data[KEEP_W-1:0];
                REG_OUTPUT_MODE: mode_next = cfg_data[MODE_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (in_accept)
                begin
                    if (counter_reg < CNT_MAX)
                    begin
                        counter_next = counter_reg + 1'b1;
                    end
                    fill_next = fill_after;
                    if (in_data.last_in)
                    begin
                        counter_next = '0;
                        fill_next    = '0;
                        if (emit_n == '0)
                        begin
                            ctrl.clear = 1'b1;
                        end
                        else
                        begin
                            remaining_next = emit_n;
                            state_next     = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load_word)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.top_value =
                        (mode_reg == MODE_INDICES) ? '0 : head.score;
                    out_data_next.class_index =
                        (mode_reg == MODE_VALUES) ? '0 : head.index;
                    out_data_next.rank_last = (remaining_reg == KEEP_W'(1));
                    remaining_next = remaining_reg - 1'b1;
                    if (remaining_reg == KEEP_W'(1))
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        ctrl.shift_up = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            counter_reg   <= '0;
            fill_reg      <= '0;
            remaining_reg <= '0;
            keep_reg      <= KEEP_RESET;
            mode_reg      <= MODE_BOTH;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            fill_reg      <= fill_next;
            remaining_reg <= remaining_next;
            keep_reg      <= keep_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // words still owed must come from a live head entry
    `TK_ASSERT_NOW(a_head_live, state_reg == ST_DRAIN, head.valid, "drain with empty chain head")
    // final word of a row leaves the chain empty
    `TK_ASSERT_NEXT(a_clear_after, last_load, !head.valid, "chain not cleared after unload")
    // position counter holds at saturation within a row
    `TK_ASSERT_NEXT(a_cnt_sat, in_accept && !in_data.last_in && cnt_full, cnt_full, "counter past limit")
    // the list never reports more entries than it holds
    `TK_ASSERT_NOW(a_emit_bound, in_accept, emit_n <= fill_after, "unload count exceeds fill")

endmodule

// ----- verif/top_k_selector_test.sv -----
// Self-checking testbench for the top-k selector: directed rows, random rows, checked per word
module top_k_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tk_pkg::*;

    localparam int MAX_CLASSES  = MAX_CLASSES_DEF;
    localparam int DRAIN_CYCLES = 80;      // longest unload (63 words) plus margin
    localparam int CYCLE_LIMIT  = 300000;  // watchdog on the whole run
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [IDX_W-1:0]          pos;
    } ranked_entry_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state and settings
    ranked_entry_t       ranked_list[$];
    int unsigned         row_position;
    logic [KEEP_W-1:0]   keep_setting;
    logic [MODE_W-1:0]   mode_setting;
    out_word_t           pending_results[$];

    bit send_gaps;
    bit stall_gaps;
    int mismatches;
    int rows_closed;
    int words_sent;
    int results_checked;
    int reg_writes;

    top_k_selector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timed out after %0d cycles, %0d results still due",
                 CYCLE_LIMIT, pending_results.size());
        $display("FAIL");
        $finish;
    end

    // Sorted insert, descending; equal scores stay in row order.
    function automatic void fold_score(in_word_t w);
        ranked_entry_t e;
        out_word_t     r;
        int            p;
        int            n;
        int            i;
        if (row_position < MAX_CLASSES)
        begin
            e.score = w.score;
            e.pos   = row_position[IDX_W-1:0];
            p = 0;
            while (p < ranked_list.size() && !(w.score > ranked_list[p].score))
                p++;
            if (p < SLOTS)
            begin
                ranked_list.insert(p, e);
                if (ranked_list.size() > SLOTS)
                    void'(ranked_list.pop_back());
            end
            row_position++;
        end
        if (w.last_in)
        begin
            n = (ranked_list.size() < keep_setting) ? ranked_list.size() : int'(keep_setting);
            for (i = 0; i < n; i++)
            begin
                r.top_value   = (mode_setting == MODE_INDICES) ? '0 : ranked_list[i].score;
                r.class_index = (mode_setting == MODE_VALUES) ? '0 : ranked_list[i].pos;
                r.rank_last   = (i == n - 1);
                pending_results.push_back(r);
            end
            ranked_list.delete();
            row_position = 0;
            rows_closed++;
        end
    endfunction

    function automatic void flag_mismatch(string what, out_word_t want, out_word_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected value %0d index %0d last %0b, ",
                      "got value %0d index %0d last %0b"},
                     $realtime, what, want.top_value, want.class_index, want.rank_last,
                     got.top_value, got.class_index, got.rank_last);
    endfunction

    // input side first, so a row closed on this edge is predicted before any word is checked
    always @(posedge clk)
    begin : result_check
        out_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                fold_score(in_data);
                words_sent++;
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result word", '0, out_data);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.top_value !== want.top_value ||
                        out_data.class_index !== want.class_index ||
                        out_data.rank_last !== want.rank_last)
                        flag_mismatch("result word differs", want, out_data);
                end
            end
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_gaps && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 9))
            0: return SCORE_MIN;
            1: return SCORE_MAX;
            2, 3, 4: return $signed(32'($urandom_range(0, 6))) - 32'sd3;  // ties likely
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // Leaves in_valid high after acceptance; the next call or wait_idle decides what follows.
    task automatic send_word(input logic signed [SCORE_W-1:0] score, input logic is_last);
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{score: score, last_in: is_last};
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_config(input logic [KEEP_W-1:0] keep, input logic [MODE_W-1:0] mode);
        cfg_valid <= 1'b1;
        cfg_index <= REG_KEEP_COUNT;
        cfg_data  <= keep;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        keep_setting = keep;
        cfg_index <= REG_OUTPUT_MODE;
        cfg_data  <= {4'($urandom_range(0, 15)), mode};  // upper bits are don't-care
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        mode_setting = mode;
        cfg_valid <= 1'b0;
        reg_writes += 2;
    endtask

    task automatic test_reset_defaults();
        send_word(32'sd5, 1'b1);
        send_word(SCORE_MIN, 1'b0);
        send_word(SCORE_MAX, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b1);
    endtask

    task automatic test_ties_and_extremes();
        wait_idle();
        set_config(6'd63, MODE_BOTH);
        send_word(32'sd7, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(SCORE_MAX, 1'b0);
        send_word(SCORE_MIN, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd0, 1'b1);
    endtask

    task automatic test_short_row();
        wait_idle();
        set_config(6'd5, MODE_BOTH);
        send_word(32'sd3, 1'b0);
        send_word(-32'sd3, 1'b0);
        send_word(32'sd40, 1'b1);
    endtask

    task automatic test_output_modes();
        logic [MODE_W-1:0] modes[3];
        int i;
        modes = '{MODE_VALUES, MODE_INDICES, MODE_UNDEF};
        for (i = 0; i < 3; i++)
        begin
            wait_idle();
            set_config(6'd2, modes[i]);
            send_word(-32'sd100, 1'b0);
            send_word(32'sd100, 1'b1);
        end
    endtask

    // nothing comes out, but the row must still be cleared
    task automatic test_keep_zero();
        wait_idle();
        set_config(6'd0, MODE_BOTH);
        send_word(32'sd9, 1'b1);
        send_word(SCORE_MIN, 1'b0);
        send_word(SCORE_MAX, 1'b1);
    endtask

    task automatic test_random_rows(input int items, input logic [KEEP_W-1:0] keep,
                                    input logic [MODE_W-1:0] mode, input bit with_gaps);
        int sent;
        int len;
        int i;
        wait_idle();
        set_config(keep, mode);
        sent = 0;
        while (sent < items)
        begin
            send_gaps  = with_gaps && ($urandom_range(0, 3) != 0);
            stall_gaps = with_gaps && ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
            if (len > items - sent)
                len = items - sent;
            for (i = 0; i < len; i++)
                send_word(pick_score(), i == len - 1);
            sent += len;
        end
    endtask

    // Full list with the 64th word dropped, then a row running past MAX_CLASSES.
    task automatic test_long_rows();
        int i;
        wait_idle();
        set_config(6'd63, MODE_BOTH);
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
        for (i = 0; i < MAX_CLASSES - 1; i++)
            send_word(pick_score(), 1'b0);
        send_word(SCORE_MIN, 1'b1);
        for (i = 0; i < MAX_CLASSES - 1; i++)
            send_word(pick_score(), 1'b0);
        // top-scoring word at the highest index; the ones past the end must not show up
        for (i = 0; i < 4; i++)
            send_word(SCORE_MAX, i == 3);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_KEEP_COUNT;
        cfg_data  <= '0;
        keep_setting = KEEP_RESET;
        mode_setting = MODE_BOTH;
        row_position = 0;
        send_gaps    = 1'b1;
        stall_gaps   = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_ties_and_extremes();
        test_short_row();
        test_output_modes();
        test_keep_zero();

        test_random_rows(15, 6'd63, MODE_BOTH, 1'b1);
        test_random_rows(15, 6'($urandom_range(1, 62)), MODE_VALUES, 1'b1);
        test_random_rows(15, 6'($urandom_range(1, 62)), MODE_INDICES, 1'b1);
        test_random_rows(8, 6'd0, MODE_UNDEF, 1'b1);
        test_random_rows(8, 6'd1, MODE_UNDEF, 1'b1);
        test_long_rows();
        test_random_rows(15, 6'($urandom_range(1, 63)), MODE_BOTH, 1'b0);
        wait_idle();

        $display("Covered %0d rows, %0d scores, %0d result words, %0d register writes",
                 rows_closed, words_sent, results_checked, reg_writes);
        $display("keep_count 0, 1, 63 and random; all four mode codes; ties, full and over-long rows");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- top_k_selector.f -----
+incdir+src
src/tk_pkg.sv
src/tk_cell.sv
src/tk_chain.sv
src/top_k_selector.sv
verif/top_k_selector_test.sv
